### sv/iee_pkg.sv
// types, codes and character constants of the expression evaluator
`default_nettype none

package iee_pkg;

  localparam int LEVELS = 32;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int ENTRY_W = 34;
  localparam int WORD_W = 32;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  typedef enum logic [1:0] {
    PH_OPERAND = 2'd0,
    PH_NUMBER  = 2'd1,
    PH_AFTER   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SYMBOL  = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_DEPTH   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_DONE,
    S_DISPATCH,
    S_POP_LOAD,
    S_END
  } state_t;

  typedef enum logic [1:0] {
    CTX_DISPATCH,
    CTX_END,
    CTX_IDLE
  } ctx_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

endpackage

`default_nettype wire

### sv/iee_char_if.sv
// character channel
`default_nettype none

interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

### sv/iee_result_if.sv
// result channel
`default_nettype none

interface iee_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

### sv/integer_expression_evaluator_unit.sv
// infix integer expression evaluator with a level stack in memory
//
//  channel   dir  payload              transaction
//  chars     in   char_code[7:0]       one character
//  results   out  value[31:0], status  one per end marker
//
// a digit is taken in the idle state; a space or operator that completes no number
// passes through dispatch; completing a number adds an apply step with multiply, and
// under divide the init, run and done states of the one-bit-per-cycle divider; a
// closing parenthesis adds a stack read and a second apply, so the worst character
// completes two divisions. the current level lives in registers, the levels below
// in two memories with registered reads; reset needs no clearing pass. an end marker
// waits in the end state only while the previous result still waits in the output register
`default_nettype none

module integer_expression_evaluator_unit
  import iee_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  iee_char_if.sink       chars,
  iee_result_if.source   results
);

  logic [ENTRY_W-1:0] sum_mem [LEVELS];
  logic [ENTRY_W-1:0] prod_mem [LEVELS];
  logic [ENTRY_W-1:0] rd_sum, rd_prod;
  logic               mem_we;
  logic [LVL_W-1:0]   mem_waddr, mem_raddr;

  state_t            state, state_next;
  ctx_t              ctx, ctx_next;
  phase_t            phase, phase_next;
  status_t           err, err_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [31:0]       num, num_next;
  logic [31:0]       sum, sum_next;
  logic              sub, sub_next;
  logic [31:0]       prod, prod_next;
  logic              divop, divop_next;
  logic [7:0]        chr, chr_next;
  logic [31:0]       opnd, opnd_next;
  logic [31:0]       dq, dq_next;
  logic [31:0]       drem, drem_next;
  logic [31:0]       dvs, dvs_next;
  logic [DIV_CNT_W-1:0] dcnt, dcnt_next;
  logic              dneg, dneg_next;
  logic              out_valid, out_valid_next;
  logic [31:0]       out_value, out_value_next;
  status_t           out_status, out_status_next;

  logic [31:0] closed;
  logic [32:0] div_shift, div_diff;
  logic [7:0]  c;
  logic        is_end, is_digit, is_space;
  status_t     end_status;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= {1'b0, sub, sum};
      prod_mem[mem_waddr] <= {1'b0, divop, prod};
    end
    rd_sum <= sum_mem[mem_raddr];
    rd_prod <= prod_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx <= CTX_IDLE;
      phase <= PH_OPERAND;
      err <= ST_OK;
      level <= '0;
      num <= '0;
      sum <= '0;
      sub <= 1'b0;
      prod <= 32'd1;
      divop <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ctx <= ctx_next;
      phase <= phase_next;
      err <= err_next;
      level <= level_next;
      num <= num_next;
      sum <= sum_next;
      sub <= sub_next;
      prod <= prod_next;
      divop <= divop_next;
      out_valid <= out_valid_next;
    end
    chr <= chr_next;
    opnd <= opnd_next;
    dq <= dq_next;
    drem <= drem_next;
    dvs <= dvs_next;
    dcnt <= dcnt_next;
    dneg <= dneg_next;
    out_value <= out_value_next;
    out_status <= out_status_next;
  end

  assign chars.ready = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.value = out_value;
  assign results.status = out_status;

  assign c = chars.char_code;
  assign is_end = (c == CH_NUL) || (c == CH_LF);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign closed = sub ? (sum - prod) : (sum + prod);
  assign div_shift = {drem, dq[31]};
  assign div_diff = div_shift - {1'b0, dvs};
  assign end_status = (err != ST_OK) ? err :
                      ((phase != PH_AFTER) || (level != '0)) ? ST_SYMBOL : ST_OK;

  always_comb begin
    is_space = (chr == CH_SPACE) || ((chr >= CH_TAB) && (chr <= CH_CR));
  end

  always_comb begin
    state_next = state;
    ctx_next = ctx;
    phase_next = phase;
    err_next = err;
    level_next = level;
    num_next = num;
    sum_next = sum;
    sub_next = sub;
    prod_next = prod;
    divop_next = divop;
    chr_next = chr;
    opnd_next = opnd;
    dq_next = dq;
    drem_next = drem;
    dvs_next = dvs;
    dcnt_next = dcnt;
    dneg_next = dneg;
    out_valid_next = out_valid && !results.ready;
    out_value_next = out_value;
    out_status_next = out_status;
    mem_we = 1'b0;
    mem_waddr = level;
    mem_raddr = level - LVL_W'(1);

    case (state)
      S_IDLE: begin
        if (chars.valid) begin
          if (is_end) begin
            if ((err == ST_OK) && (phase == PH_NUMBER)) begin
              opnd_next = num;
              phase_next = PH_AFTER;
              ctx_next = CTX_END;
              state_next = S_APPLY;
            end else begin
              state_next = S_END;
            end
          end else if (err != ST_OK) begin
            state_next = S_IDLE;
          end else if (is_digit) begin
            case (phase)
              PH_OPERAND: begin
                num_next = 32'(c[3:0]);
                phase_next = PH_NUMBER;
              end
              PH_NUMBER: num_next = (num << 3) + (num << 1) + 32'(c[3:0]);
              default: err_next = ST_SYMBOL;
            endcase
          end else if (phase == PH_NUMBER) begin
            opnd_next = num;
            phase_next = PH_AFTER;
            chr_next = c;
            ctx_next = CTX_DISPATCH;
            state_next = S_APPLY;
          end else begin
            chr_next = c;
            state_next = S_DISPATCH;
          end
        end
      end

      S_APPLY: begin
        if (divop) begin
          if (opnd == '0) begin
            err_next = ST_DIVZERO;
            state_next = (ctx == CTX_END) ? S_END : S_IDLE;
          end else begin
            state_next = S_DIV_INIT;
          end
        end else begin
          prod_next = prod * opnd;
          case (ctx)
            CTX_DISPATCH: state_next = S_DISPATCH;
            CTX_END: state_next = S_END;
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_DIV_INIT: begin
        dq_next = prod[31] ? (32'd0 - prod) : prod;
        dvs_next = opnd[31] ? (32'd0 - opnd) : opnd;
        dneg_next = prod[31] ^ opnd[31];
        drem_next = '0;
        dcnt_next = '0;
        state_next = S_DIV_RUN;
      end

      S_DIV_RUN: begin
        if (!div_diff[32]) begin
          drem_next = div_diff[31:0];
          dq_next = {dq[30:0], 1'b1};
        end else begin
          drem_next = div_shift[31:0];
          dq_next = {dq[30:0], 1'b0};
        end
        dcnt_next = dcnt + DIV_CNT_W'(1);
        if (dcnt == DIV_CNT_W'(WORD_W - 1)) begin
          state_next = S_DIV_DONE;
        end
      end

      S_DIV_DONE: begin
        prod_next = dneg ? (32'd0 - dq) : dq;
        divop_next = 1'b0;
        case (ctx)
          CTX_DISPATCH: state_next = S_DISPATCH;
          CTX_END: state_next = S_END;
          default: state_next = S_IDLE;
        endcase
      end

      S_DISPATCH: begin
        state_next = S_IDLE;
        if (is_space) begin
          state_next = S_IDLE;
        end else begin
          case (chr)
            CH_LPAREN: begin
              if (phase != PH_OPERAND) begin
                err_next = ST_SYMBOL;
              end else if (level != LVL_W'(LEVELS - 1)) begin
                mem_we = 1'b1;
                level_next = level + LVL_W'(1);
                sum_next = '0;
                sub_next = 1'b0;
                prod_next = 32'd1;
                divop_next = 1'b0;
              end else begin
                err_next = ST_DEPTH;
              end
            end
            CH_RPAREN: begin
              if ((phase != PH_AFTER) || (level == '0)) begin
                err_next = ST_SYMBOL;
              end else begin
                opnd_next = closed;
                level_next = level - LVL_W'(1);
                state_next = S_POP_LOAD;
              end
            end
            CH_STAR, CH_SLASH: begin
              if (phase != PH_AFTER) begin
                err_next = ST_SYMBOL;
              end else begin
                if (chr == CH_SLASH) begin
                  divop_next = 1'b1;
                end
                phase_next = PH_OPERAND;
              end
            end
            CH_PLUS, CH_MINUS: begin
              if (phase != PH_AFTER) begin
                err_next = ST_SYMBOL;
              end else begin
                sum_next = closed;
                sub_next = (chr == CH_MINUS);
                prod_next = 32'd1;
                divop_next = 1'b0;
                phase_next = PH_OPERAND;
              end
            end
            default: err_next = ST_SYMBOL;
          endcase
        end
      end

      S_POP_LOAD: begin
        sum_next = rd_sum[31:0];
        sub_next = rd_sum[32];
        prod_next = rd_prod[31:0];
        divop_next = rd_prod[32];
        ctx_next = CTX_IDLE;
        state_next = S_APPLY;
      end

      S_END: begin
        if (!out_valid || results.ready) begin
          out_valid_next = 1'b1;
          out_status_next = end_status;
          out_value_next = (end_status == ST_OK) ? closed : '0;
          phase_next = PH_OPERAND;
          err_next = ST_OK;
          level_next = '0;
          num_next = '0;
          sum_next = '0;
          sub_next = 1'b0;
          prod_next = 32'd1;
          divop_next = 1'b0;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
